/* hdl/fde_pkg.sv */
`timescale 1ns / 1ps

package fde_pkg;

   localparam int MAX_DELAY_DEF   = 131072;
   localparam int CHANNELS_DEF    = 2;
   localparam int SAMPLE_BITS_DEF = 24;

   localparam int DELAY_BITS      = 17;
   localparam int GAIN_BITS       = 16;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 17;

   localparam int GAIN_SHIFT      = 15;
   localparam int GAIN_HALF       = 16384;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_DELAY_SAMPLES = 2'd0;
   localparam csr_index_type CSR_FEEDBACK_GAIN = 2'd1;
   localparam csr_index_type CSR_MIX_GAIN      = 2'd2;

   localparam logic [DELAY_BITS-1:0] DELAY_RESET = 17'd24000;
   localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = 16'd16384;

endpackage

/* hdl/fde_ram.sv */
`timescale 1ns / 1ps

module fde_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 262144
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read and a write to one address in the same cycle return old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/feedback_delay_echo.sv */
`timescale 1ns / 1ps

// Per-channel feedback echo. Each item is one sample of one channel; the block returns
// dry plus mix_gain times the sample written delay_samples items of that channel earlier,
// and stores dry plus feedback_gain times that sample back into the channel's circular
// buffer (both sums rounded and saturated). Throughput is one item per clock when no
// stall holds the pipeline; a request passes the stage 1, stage 2 and output registers
// on its way to the response. The buffer is one single-port-write, registered-read RAM
// with a read-modify-write pipeline of three stages; when an item's read address matches
// an entry still being computed by one of the two items ahead of it (same channel,
// effective delay of 1 or 2), the request is stalled until that write lands; a stall on
// the response side extends the wait. No clearing pass is needed after reset: a wrap flag
// per channel makes never-written entries read as zero, so items are taken right away.
module feedback_delay_echo #(
   parameter int MAX_DELAY   = fde_pkg::MAX_DELAY_DEF,
   parameter int CHANNELS    = fde_pkg::CHANNELS_DEF,
   parameter int SAMPLE_BITS = fde_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_channel,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample_in,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_channel_out,
   output logic signed [SAMPLE_BITS-1:0]      rsp_sample_out,

   input  logic                               csr_wr_en,
   input  fde_pkg::csr_index_type             csr_index,
   input  logic [fde_pkg::CSR_DATA_BITS-1:0]  csr_wr_data
);

   localparam int PW    = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
   localparam int DEPTH = CHANNELS * MAX_DELAY;
   localparam int AW    = $clog2(DEPTH);
   localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int EW    = (PW > fde_pkg::DELAY_BITS) ? PW : fde_pkg::DELAY_BITS;
   localparam int PB    = SAMPLE_BITS + fde_pkg::GAIN_BITS + 1;

   localparam logic [PW-1:0] POS_LAST  = PW'(MAX_DELAY - 1);
   localparam logic [EW-1:0] DLY_MAX   = EW'(MAX_DELAY - 1);
   localparam logic [AW-1:0] CH_STRIDE = AW'(MAX_DELAY);
   localparam logic signed [PB-1:0] SAT_HI   = (PB'(1) <<< (SAMPLE_BITS - 1)) - PB'(1);
   localparam logic signed [PB-1:0] SAT_LO   = -SAT_HI - PB'(1);
   localparam logic signed [PB-1:0] ROUND_HF = PB'(fde_pkg::GAIN_HALF);

   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [PB-1:0] v);
      logic signed [SAMPLE_BITS-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[SAMPLE_BITS-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         r = v[SAMPLE_BITS-1:0];
      end
      return r;
   endfunction

   // configuration
   logic [fde_pkg::DELAY_BITS-1:0] csr_delay_ff;
   logic [fde_pkg::GAIN_BITS-1:0]  csr_fb_gain_ff;
   logic [fde_pkg::GAIN_BITS-1:0]  csr_mix_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_delay_ff    <= fde_pkg::DELAY_RESET;
         csr_fb_gain_ff  <= fde_pkg::GAIN_RESET;
         csr_mix_gain_ff <= fde_pkg::GAIN_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            fde_pkg::CSR_DELAY_SAMPLES: csr_delay_ff <= csr_wr_data[fde_pkg::DELAY_BITS-1:0];
            fde_pkg::CSR_FEEDBACK_GAIN: csr_fb_gain_ff <= csr_wr_data[fde_pkg::GAIN_BITS-1:0];
            fde_pkg::CSR_MIX_GAIN:      csr_mix_gain_ff <= csr_wr_data[fde_pkg::GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // effective delay, clamped to [1, MAX_DELAY-1]
   logic [EW-1:0] dly_ext;
   logic [PW-1:0] dly;

   always_comb begin
      dly_ext = EW'(csr_delay_ff);
      if (dly_ext == '0) begin
         dly_ext = EW'(1);
      end else if (dly_ext > DLY_MAX) begin
         dly_ext = DLY_MAX;
      end
      dly = dly_ext[PW-1:0];
   end

   // pipeline control
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic out_free, s2_free, s1_free, s2_go, s1_go;
   logic hazard, accept;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s2_go    = s2_valid_ff && out_free;
   assign s2_free  = !s2_valid_ff || out_free;
   assign s1_go    = s1_valid_ff && s2_free;
   assign s1_free  = !s1_valid_ff || s2_free;

   // stage 0: address generation
   logic [PW-1:0] wp_ff  [CHANNELS];
   logic          wrapped_ff [CHANNELS];
   logic [CHW-1:0] chi;
   logic [PW-1:0]  wp_cur, wp_in, rp;
   logic [PW:0]    rp_wide;
   logic           fill_ok;
   logic [AW-1:0]  rd_addr, wr_addr;

   always_comb begin
      chi     = (CHANNELS > 1) ? CHW'(req_channel) : '0;
      wp_cur  = wp_ff[chi];
      rp_wide = {1'b0, wp_cur} + (PW + 1)'(MAX_DELAY) - {1'b0, dly};
      rp      = (wp_cur >= dly) ? (wp_cur - dly) : rp_wide[PW-1:0];
      fill_ok = wrapped_ff[chi] || (wp_cur >= dly);
      wp_in   = (wp_cur == POS_LAST) ? '0 : wp_cur + PW'(1);
      rd_addr = AW'(chi) * CH_STRIDE + AW'(rp);
      wr_addr = AW'(chi) * CH_STRIDE + AW'(wp_cur);
   end

   logic [AW-1:0] s1_waddr_ff, s2_waddr_ff;

   assign hazard    = (s1_valid_ff && s1_waddr_ff == rd_addr)
                   || (s2_valid_ff && s2_waddr_ff == rd_addr);
   assign req_stall = !s1_free || hazard;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            wp_ff[i]      <= '0;
            wrapped_ff[i] <= 1'b0;
         end
      end else if (accept) begin
         wp_ff[chi] <= wp_in;
         if (wp_cur == POS_LAST) begin
            wrapped_ff[chi] <= 1'b1;
         end
      end
   end

   // delay store
   logic signed [SAMPLE_BITS-1:0] ram_rdata;
   logic signed [SAMPLE_BITS-1:0] fb_sum, wet_sum;

   fde_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (s2_go),
      .wr_addr (s2_waddr_ff),
      .wr_data (fb_sum),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // stage 1: gain products
   logic                          s1_ch_ff, s1_fill_ff;
   logic signed [SAMPLE_BITS-1:0] s1_dry_ff, s1_delayed;
   logic signed [PB-1:0]          fb_prod_in, mix_prod_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept || (s1_valid_ff && !s2_free);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ch_ff    <= req_channel;
         s1_fill_ff  <= fill_ok;
         s1_dry_ff   <= req_sample_in;
         s1_waddr_ff <= wr_addr;
      end
   end

   always_comb begin
      s1_delayed  = s1_fill_ff ? ram_rdata : '0;
      fb_prod_in  = PB'(s1_delayed) * PB'($signed({1'b0, csr_fb_gain_ff}));
      mix_prod_in = PB'(s1_delayed) * PB'($signed({1'b0, csr_mix_gain_ff}));
   end

   // stage 2: round, add, saturate, write back
   logic                          s2_ch_ff;
   logic signed [SAMPLE_BITS-1:0] s2_dry_ff;
   logic signed [PB-1:0]          s2_fb_prod_ff, s2_mix_prod_ff;
   logic signed [PB-1:0]          fb_round, mix_round;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_go || (s2_valid_ff && !out_free);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s2_ch_ff       <= s1_ch_ff;
         s2_dry_ff      <= s1_dry_ff;
         s2_waddr_ff    <= s1_waddr_ff;
         s2_fb_prod_ff  <= fb_prod_in;
         s2_mix_prod_ff <= mix_prod_in;
      end
   end

   always_comb begin
      fb_round  = (s2_fb_prod_ff + ROUND_HF) >>> fde_pkg::GAIN_SHIFT;
      mix_round = (s2_mix_prod_ff + ROUND_HF) >>> fde_pkg::GAIN_SHIFT;
      fb_sum    = sat_sample(PB'(s2_dry_ff) + fb_round);
      wet_sum   = sat_sample(PB'(s2_dry_ff) + mix_round);
   end

   // output register
   logic                          rsp_channel_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_go || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go) begin
         rsp_channel_ff <= s2_ch_ff;
         rsp_sample_ff  <= wet_sum;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_channel_out = rsp_channel_ff;
   assign rsp_sample_out  = rsp_sample_ff;

   // checks
   a_no_read_of_pending_write: assert property (@(posedge clock) disable iff (reset)
      accept |-> !(s2_go && s2_waddr_ff == rd_addr))
      else $error("read issued to an entry with a write still in flight");

   a_wp_in_range: assert property (@(posedge clock) disable iff (reset)
      accept |-> (wp_cur <= POS_LAST && rp <= POS_LAST))
      else $error("buffer position out of range");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_free) |=> (s1_valid_ff && $stable(s1_waddr_ff) && $stable(ram_rdata)))
      else $error("stage 1 lost its item while stalled");

   a_s2_holds: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !out_free) |=> (s2_valid_ff && $stable(s2_fb_prod_ff)))
      else $error("stage 2 lost its item while stalled");

endmodule
